// ===== src/acbs_pkg.sv =====
// ----------------------------------------------------------------------------
// acbs_pkg: shared types and constants of the call / branch seed scanner
// Item and result layouts, opcodes, instruction match patterns and the
// work record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package acbs_pkg;

  // default table sizes
  localparam int FUNC_DEPTH_DEF  = 256;
  localparam int RANGE_DEPTH_DEF = 8;

  // branches no farther than this many bytes make no seed
  localparam int REGION_WINDOW = 128;

  // opcodes
  localparam logic [1:0] OP_RANGE  = 2'd0;
  localparam logic [1:0] OP_FUNC   = 2'd1;
  localparam logic [1:0] OP_SCAN   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;   // no effect, no seed

  // seed kinds
  localparam logic KIND_RET    = 1'b0;
  localparam logic KIND_BRANCH = 1'b1;

  // instruction match patterns
  localparam logic [31:0] MASK_IMM26 = 32'hFC00_0000;
  localparam logic [31:0] PAT_BL     = 32'h9400_0000;
  localparam logic [31:0] PAT_B      = 32'h1400_0000;
  localparam logic [31:0] MASK_BLR   = 32'hFFFF_FC1F;
  localparam logic [31:0] PAT_BLR    = 32'hD63F_0000;
  localparam logic [31:0] MASK_BCOND = 32'hFF00_0010;
  localparam logic [31:0] PAT_BCOND  = 32'h5400_0000;
  localparam logic [31:0] MASK_CMPBR = 32'h7E00_0000;
  localparam logic [31:0] PAT_CB     = 32'h3400_0000;
  localparam logic [31:0] PAT_TB     = 32'h3600_0000;

  // input item
  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] address;
    logic [63:0] range_size;
    logic [31:0] instruction_word;
  } acbs_item_t;

  // result item
  typedef struct packed {
    logic [63:0] seed_address;
    logic        seed_kind;
  } acbs_seed_t;

  // classified item from front end to back end
  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] address;
    logic [63:0] range_size;
    logic [63:0] target;   // BL target or direct branch target
    logic        is_bl;
    logic        is_blr;
    logic        is_far;   // direct branch farther than the window
  } acbs_work_t;

endpackage

// ===== src/aarch64_call_branch_seed_scan.sv =====
// ----------------------------------------------------------------------------
// aarch64_call_branch_seed_scan: AArch64 call / branch seed scanner
// Keeps executable ranges and function starts and scans instruction words
// for return points after calls and far direct branch targets.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive item and push; a transfer happens when full is low.
//   Opcode 0 adds a range, 1 adds a function start, 2 scans a word at a PC.
//   Result queue: while empty is low, seed holds the oldest seed; pop takes it.
//   Only scans give seeds, zero or one per scanned word.
//   Configuration: APB register 0 (address 0) holds branches_enabled in bit 0.
// Sequencing (one item at a time in the back end):
//   range insert passes S_DEC only; a BLR call scan goes S_DEC, S_EMIT and a
//   far branch scan S_DEC, S_RANGE, S_RDONE, S_EMIT, then the result register
//   loads. BL scan and function insert walk the function table RAM in order
//   in S_SCAN (one read a cycle), which sets the rate.
//   A two-entry queue lets the input side accept while the back end works.
// Reset: range and function counts clear, lowest start goes to all ones,
//   branches_enabled goes to 1, both queues empty. No clearing pass.
// Stall: a waiting seed holds the back end only when the next seed is ready;
//   the input queue then fills and full rises.
// ----------------------------------------------------------------------------
module aarch64_call_branch_seed_scan #(
  parameter int FUNC_DEPTH  = acbs_pkg::FUNC_DEPTH_DEF,
  parameter int RANGE_DEPTH = acbs_pkg::RANGE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  acbs_pkg::acbs_item_t item,
  output logic               empty,
  input  logic               pop,
  output acbs_pkg::acbs_seed_t seed,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import acbs_pkg::*;

  logic       branches_enabled;
  logic       q_valid, q_pop, out_valid;
  acbs_work_t q_item;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, branches_enabled} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      branches_enabled <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      branches_enabled <= pwdata[0];
    end
  end

  acbs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  acbs_back #(
    .FUNC_DEPTH  (FUNC_DEPTH),
    .RANGE_DEPTH (RANGE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .br_en     (branches_enabled),
    .out_valid (out_valid),
    .seed      (seed),
    .out_pop   (pop)
  );

  assign empty = !out_valid;

endmodule

// ===== src/acbs_ram.sv =====
// ----------------------------------------------------------------------------
// acbs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module acbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/acbs_front.sv =====
// ----------------------------------------------------------------------------
// acbs_front: input classification and work queue
// Decodes the instruction word, computes the branch target and window
// test, and holds up to two classified items for the back end.
// ----------------------------------------------------------------------------
module acbs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  acbs_pkg::acbs_item_t item,
  output logic               q_valid,
  output acbs_pkg::acbs_work_t q_item,
  input  logic               q_pop
);
  import acbs_pkg::*;

  logic [31:0] w;
  logic        is_bl, is_blr, is_b, is_cond, is_tb;
  logic [28:0] off26, off19, off14, off, mag;
  acbs_work_t  work;

  // instruction classes
  assign w       = item.instruction_word;
  assign is_bl   = (w & MASK_IMM26) == PAT_BL;
  assign is_blr  = (w & MASK_BLR) == PAT_BLR;
  assign is_b    = (w & MASK_IMM26) == PAT_B;
  assign is_cond = ((w & MASK_BCOND) == PAT_BCOND) || ((w & MASK_CMPBR) == PAT_CB);
  assign is_tb   = (w & MASK_CMPBR) == PAT_TB;

  // word offsets, sign-extended and scaled by 4
  assign off26 = {w[25], w[25:0], 2'b00};
  assign off19 = {{8{w[23]}}, w[23:5], 2'b00};
  assign off14 = {{13{w[18]}}, w[18:5], 2'b00};

  always_comb begin
    if (is_bl || is_b) begin
      off = off26;
    end else if (is_cond) begin
      off = off19;
    end else begin
      off = off14;
    end
  end

  assign mag = off[28] ? (~off + 29'd1) : off;

  // classified record
  always_comb begin
    work.opcode     = item.opcode;
    work.address    = item.address;
    work.range_size = item.range_size;
    work.target     = item.address + {{35{off[28]}}, off};
    work.is_bl      = is_bl;
    work.is_blr     = is_blr;
    work.is_far     = (is_b || is_cond || is_tb) && (mag > 29'(REGION_WINDOW));
  end

  // two-entry queue
  acbs_work_t  qmem [2];
  logic        wp, rp;
  logic [1:0]  cnt;
  logic        do_push, do_pop;

  assign full    = cnt == 2'd2;
  assign q_valid = cnt != 2'd0;
  assign q_item  = qmem[rp];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      qmem[wp] <= work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== src/acbs_back.sv =====
// ----------------------------------------------------------------------------
// acbs_back: table keeper and seed generator
// Holds the range table and the function start table, runs the range and
// membership checks for each classified item and drives the result register.
// ----------------------------------------------------------------------------
module acbs_back #(
  parameter int FUNC_DEPTH  = acbs_pkg::FUNC_DEPTH_DEF,
  parameter int RANGE_DEPTH = acbs_pkg::RANGE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  acbs_pkg::acbs_work_t q_item,
  output logic               q_pop,
  input  logic               br_en,
  output logic               out_valid,
  output acbs_pkg::acbs_seed_t seed,
  input  logic               out_pop
);
  import acbs_pkg::*;

  localparam int FCNT_W = $clog2(FUNC_DEPTH + 1);
  localparam int FIDX_W = (FUNC_DEPTH > 1) ? $clog2(FUNC_DEPTH) : 1;
  localparam int RCNT_W = $clog2(RANGE_DEPTH + 1);
  localparam int RIDX_W = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_RANGE = 6'b000100,
    S_RDONE = 6'b001000,
    S_SCAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t              state;
  acbs_work_t          it;
  logic [63:0]         rng_base [RANGE_DEPTH];
  logic [63:0]         rng_len  [RANGE_DEPTH];
  logic [RCNT_W-1:0]   rcount;
  logic [FCNT_W-1:0]   fcount;
  logic [FCNT_W-1:0]   iss;
  logic [63:0]         lowest;
  logic                rvld, fhit, rhit, emit_kind;

  logic [63:0]         key, rd_data;
  logic                exec_hit, blr_call, br_go, scan_done, ffull, ram_we, ram_re;

  // address under test: function start for inserts, target for scans
  assign key = (it.opcode == OP_FUNC) ? it.address : it.target;

  // range membership over all valid entries
  always_comb begin
    exec_hit = 1'b0;
    for (int i = 0; i < RANGE_DEPTH; i++) begin
      if ((RCNT_W'(i) < rcount) && (rng_len[i] >= 64'd4) && (key >= rng_base[i]) &&
          ((key - rng_base[i]) <= (rng_len[i] - 64'd4))) begin
        exec_hit = 1'b1;
      end
    end
  end

  // call and branch gates
  assign ffull     = fcount == FCNT_W'(FUNC_DEPTH);
  assign blr_call  = (fcount != '0) && (it.address > lowest);
  assign br_go     = br_en && (fcount != '0) && !(it.address < lowest) && it.is_far;
  assign scan_done = fhit || ((iss == fcount) && !rvld);

  // queue and memory controls
  assign q_pop  = (state == S_IDLE) && q_valid;
  assign ram_re = (state == S_SCAN) && (iss < fcount);
  assign ram_we = (state == S_SCAN) && scan_done && (it.opcode == OP_FUNC) && !fhit;

  acbs_ram #(
    .WIDTH (64),
    .DEPTH (FUNC_DEPTH)
  ) u_func_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fcount[FIDX_W-1:0]),
    .wdata (it.address),
    .re    (ram_re),
    .raddr (iss[FIDX_W-1:0]),
    .rdata (rd_data)
  );

  // item latch and range table payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      it <= q_item;
    end
    if ((state == S_DEC) && (it.opcode == OP_RANGE) && (rcount < RCNT_W'(RANGE_DEPTH))) begin
      rng_base[rcount[RIDX_W-1:0]] <= it.address;
      rng_len[rcount[RIDX_W-1:0]]  <= it.range_size;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rcount    <= '0;
      fcount    <= '0;
      lowest    <= '1;
      out_valid <= 1'b0;
      rvld      <= 1'b0;
      fhit      <= 1'b0;
      iss       <= '0;
    end else begin
      // result register: load on emit, clear on a result transfer
      if ((state == S_EMIT) && (!out_valid || out_pop)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          iss  <= '0;
          rvld <= 1'b0;
          fhit <= 1'b0;
          case (it.opcode)
            OP_RANGE: begin
              if (rcount < RCNT_W'(RANGE_DEPTH)) begin
                rcount <= rcount + 1'b1;
              end
              state <= S_IDLE;
            end
            OP_FUNC: begin
              state <= ((it.address[1:0] == 2'b00) && !ffull) ? S_RANGE : S_IDLE;
            end
            OP_SCAN: begin
              if (it.is_bl) begin
                state <= S_SCAN;
              end else if (it.is_blr && blr_call) begin
                emit_kind <= KIND_RET;
                state     <= S_EMIT;
              end else begin
                state <= br_go ? S_RANGE : S_IDLE;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_RANGE: begin
          rhit  <= exec_hit;
          state <= S_RDONE;
        end
        S_RDONE: begin
          if (!rhit) begin
            state <= S_IDLE;
          end else if (it.opcode == OP_FUNC) begin
            state <= S_SCAN;
          end else begin
            emit_kind <= KIND_BRANCH;
            state     <= S_EMIT;
          end
        end
        S_SCAN: begin
          // one table read issued per cycle, compared in the cycle after its issue
          rvld <= (iss < fcount) && !scan_done;
          if (iss < fcount) begin
            iss <= iss + 1'b1;
          end
          if (rvld && (rd_data == key)) begin
            fhit <= 1'b1;
          end
          if (scan_done) begin
            if (it.opcode == OP_FUNC) begin
              if (!fhit) begin
                fcount <= fcount + 1'b1;
                if (it.address < lowest) begin
                  lowest <= it.address;
                end
              end
              state <= S_IDLE;
            end else if (fhit) begin
              emit_kind <= KIND_RET;
              state     <= S_EMIT;
            end else begin
              state <= br_go ? S_RANGE : S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_pop) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!out_valid || out_pop)) begin
      seed.seed_address <= (emit_kind == KIND_BRANCH) ? it.target : (it.address + 64'd4);
      seed.seed_kind    <= emit_kind;
    end
  end

  // checks
  a_fcount_bound: assert property (@(posedge clk) disable iff (rst)
    fcount <= FCNT_W'(FUNC_DEPTH)) else $error("function count overflow");

  a_rcount_bound: assert property (@(posedge clk) disable iff (rst)
    rcount <= RCNT_W'(RANGE_DEPTH)) else $error("range count overflow");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (iss <= fcount)) else $error("scan index past count");

  a_fcount_step: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && (fcount != $past(fcount))) |-> (fcount == $past(fcount) + 1'b1))
    else $error("function count jumped");

endmodule
